[rtl/pidj_pkg.sv]
// Package for the jerk-limited PID controller.
// Holds the word types, register indexes, sequencer states and the
// command and status structs shared by the controller and the datapath.
package pidj_pkg;

  localparam int SETTLE_TICKS = 10;
  localparam int CNT_W        = $clog2(SETTLE_TICKS + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JERK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DBAND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLR_EN  = 3'd7;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [16:0] Q16_ONE = 17'd65536;

  typedef struct packed {
    logic               action;
    logic signed [31:0] error_in;
  } pidj_in_t;

  typedef struct packed {
    logic signed [31:0] correction;
    logic               integral_held;
  } pidj_out_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_RAW    = 9'b000000010,
    ST_SMOOTH = 9'b000000100,
    ST_PROP   = 9'b000001000,
    ST_IHI    = 9'b000010000,
    ST_ILO    = 9'b000100000,
    ST_DER    = 9'b001000000,
    ST_JERK   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic   load;
    logic   clear;
    logic   emit;
    state_t step;
  } pidj_cmd_t;

  typedef struct packed {
    logic out_busy;
  } pidj_sts_t;

endpackage

[rtl/pidj_mul.sv]
// Shared signed 33 by 33 bit multiplier with a registered product.
// Depends on nothing but the clock; used by the PID datapath.
module pidj_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

[rtl/pidj_datapath.sv]
// Datapath of the jerk-limited PID controller: registers, state and output word.
// Uses pidj_pkg and the shared multiplier pidj_mul; steps come from pidj_ctrl.
module pidj_datapath import pidj_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pidj_cmd_t             cmd,
  output pidj_sts_t             sts,
  input  pidj_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pidj_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] x);
    logic signed [63:0] s;
    s = x + 64'sd32768;
    return s[63:16];
  endfunction

  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [46:0]        limit_r;
  logic [30:0]        mjerk_r;
  logic [30:0]        dband_r;
  logic [16:0]        smooth_r;
  logic               clr_en_r;
  logic [16:0]        smooth_nxt;

  logic signed [47:0] integ_r;
  logic signed [31:0] prev_err_r;
  logic signed [31:0] prev_der_r;
  logic signed [31:0] prev_pi_r;
  logic               have_prev_r;
  logic [CNT_W-1:0]   cnt_r;

  logic signed [31:0] err_r;
  logic signed [32:0] raw_r;
  logic               band_r;
  logic signed [48:0] itmp_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] deriv_r;
  logic signed [31:0] pi_r;
  logic signed [47:0] dterm_r;
  logic               out_valid_r;
  pidj_out_t          out_data_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [63:0] prod64;
  logic signed [47:0] prod_rnd;
  logic signed [47:0] acc_rnd;

  logic [31:0]        err_abs;
  logic               band_nxt;
  logic signed [48:0] itmp_nxt;
  logic signed [48:0] lim49;
  logic signed [48:0] iclamp;
  logic               settle;
  logic [CNT_W-1:0]   cnt_nxt;
  logic signed [33:0] lo_raw, hi_raw, lo_c, hi_c;
  logic signed [63:0] lo64, hi64, pi_cl;
  logic signed [63:0] corr_sum;
  logic signed [31:0] corr;

  // Configuration registers.
  assign smooth_nxt = (cfg_data[16:0] > Q16_ONE) ? Q16_ONE : cfg_data[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      limit_r  <= '0;
      mjerk_r  <= 31'h7FFFFFFF;
      dband_r  <= '0;
      smooth_r <= '0;
      clr_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:     kp_r     <= cfg_data[31:0];
        REG_KI:     ki_r     <= cfg_data[31:0];
        REG_KD:     kd_r     <= cfg_data[31:0];
        REG_ILIMIT: limit_r  <= cfg_data[46:0];
        REG_JERK:   mjerk_r  <= cfg_data[30:0];
        REG_DBAND:  dband_r  <= cfg_data[30:0];
        REG_SMOOTH: smooth_r <= smooth_nxt;
        REG_CLR_EN: clr_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Multiplier operand selection, one product per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      ST_RAW: begin
        mul_a = raw_r;
        mul_b = {16'b0, Q16_ONE - smooth_r};
      end
      ST_SMOOTH: begin
        mul_a = {prev_der_r[31], prev_der_r};
        mul_b = {16'b0, smooth_r};
      end
      ST_PROP: begin
        mul_a = {kp_r[31], kp_r};
        mul_b = {err_r[31], err_r};
      end
      ST_IHI: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {integ_r[47], integ_r[47:16]};
      end
      ST_ILO: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {17'b0, integ_r[15:0]};
      end
      ST_DER: begin
        mul_a = {kd_r[31], kd_r};
        mul_b = {deriv_r[31], deriv_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidj_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod64   = prod_r[63:0];
  assign prod_rnd = rnd_q16(prod64);
  assign acc_rnd  = rnd_q16(acc_r);

  // Tick front end: deadband test and integral accumulation.
  assign err_abs  = in_data.error_in[31] ? 32'(-in_data.error_in) : in_data.error_in;
  assign band_nxt = err_abs <= {1'b0, dband_r};
  assign itmp_nxt = {integ_r[47], integ_r} +
                    (band_nxt ? 49'sd0 : {{17{in_data.error_in[31]}}, in_data.error_in});

  assign lim49  = {2'b0, limit_r};
  assign iclamp = (itmp_r > lim49) ? lim49 : ((itmp_r < -lim49) ? -lim49 : itmp_r);
  assign settle = clr_en_r && band_r && (raw_r == 33'sd0);
  assign cnt_nxt = !settle ? '0 :
                   ((cnt_r < CNT_W'(SETTLE_TICKS)) ? cnt_r + 1'b1 : cnt_r);

  // Jerk window around the last P+I term; zero is always inside it.
  assign lo_raw = {{2{prev_pi_r[31]}}, prev_pi_r} - {3'b0, mjerk_r};
  assign hi_raw = {{2{prev_pi_r[31]}}, prev_pi_r} + {3'b0, mjerk_r};
  assign lo_c   = (lo_raw > 34'sd0) ? 34'sd0 : lo_raw;
  assign hi_c   = (hi_raw < 34'sd0) ? 34'sd0 : hi_raw;
  assign lo64   = {{30{lo_c[33]}}, lo_c};
  assign hi64   = {{30{hi_c[33]}}, hi_c};
  assign pi_cl  = (acc_r < lo64) ? lo64 : ((acc_r > hi64) ? hi64 : acc_r);

  assign corr_sum = {{32{pi_r[31]}}, pi_r} +
                    (have_prev_r ? {{16{dterm_r[47]}}, dterm_r} : 64'sd0);
  assign corr     = sat32(corr_sum);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= in_data.error_in;
      band_r <= band_nxt;
      itmp_r <= itmp_nxt;
      raw_r  <= {in_data.error_in[31], in_data.error_in} - {prev_err_r[31], prev_err_r};
    end
    case (cmd.step)
      ST_SMOOTH: acc_r <= prod64;
      ST_PROP:   acc_r <= acc_r + prod64;
      ST_IHI: begin
        deriv_r <= sat32({{16{acc_rnd[47]}}, acc_rnd});
        acc_r   <= {{16{prod_rnd[47]}}, prod_rnd};
      end
      ST_ILO:    acc_r <= acc_r + prod64;
      ST_DER:    acc_r <= acc_r + {{16{prod_rnd[47]}}, prod_rnd};
      ST_JERK: begin
        pi_r    <= sat32(pi_cl);
        dterm_r <= prod_rnd;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_data_r.correction    <= corr;
      out_data_r.integral_held <= cnt_r >= CNT_W'(SETTLE_TICKS);
    end
  end

  // Controller state carried from tick to tick.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      integ_r     <= '0;
      prev_err_r  <= '0;
      prev_der_r  <= '0;
      prev_pi_r   <= '0;
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.step == ST_RAW) begin
        integ_r <= settle ? 48'sd0 : iclamp[47:0];
        cnt_r   <= cnt_nxt;
      end
      if (cmd.emit) begin
        prev_err_r  <= err_r;
        prev_der_r  <= have_prev_r ? deriv_r : 32'sd0;
        prev_pi_r   <= pi_r;
        have_prev_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_ready))
    else $error("result written over a word still waiting");

  a_rose_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output valid without a finished tick");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SETTLE_TICKS))
    else $error("settled count beyond its ceiling");

  a_integ_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_SMOOTH) |->
      ((integ_r <= lim49) && (integ_r >= -lim49)))
    else $error("integral outside its limit after the clamp");

endmodule

[rtl/pidj_ctrl.sv]
// Sequencer of the jerk-limited PID controller, one-hot state machine.
// Uses pidj_pkg; drives step commands into pidj_datapath.
module pidj_ctrl import pidj_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  pidj_sts_t sts,
  output pidj_cmd_t cmd
);

  state_t state_r, state_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign cmd.load  = in_ready && in_valid && (in_action == ACT_TICK);
  assign cmd.clear = in_ready && in_valid && (in_action == ACT_CLEAR);
  assign cmd.emit  = (state_r == ST_OUT) && !sts.out_busy;
  assign cmd.step  = state_r;

  always_comb begin
    case (state_r)
      ST_IDLE:   state_nxt = cmd.load ? ST_RAW : ST_IDLE;
      ST_RAW:    state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_PROP;
      ST_PROP:   state_nxt = ST_IHI;
      ST_IHI:    state_nxt = ST_ILO;
      ST_ILO:    state_nxt = ST_DER;
      ST_DER:    state_nxt = ST_JERK;
      ST_JERK:   state_nxt = ST_OUT;
      ST_OUT:    state_nxt = sts.out_busy ? ST_OUT : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/pid_controller_jerk_limited.sv]
// Jerk-limited PID controller, Q16.16, one tick word in, one result word out.
// A tick word or clear word is accepted only in idle; a clear keeps it idle.
// A tick's result is written after steps RAW, SMOOTH, PROP, IHI, ILO, DER,
// JERK, OUT (held while a result waits): six products share one multiplier.
// Synchronous active-low reset restores registers and state; no clearing pass.
module pid_controller_jerk_limited import pidj_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pidj_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pidj_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pidj_cmd_t cmd;
  pidj_sts_t sts;

  pidj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidj_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

[tb/pid_controller_jerk_limited_test.sv]
// Self-checking testbench for the jerk-limited PID controller.
// Tick and clear words go in with random gaps and results are taken under
// receiver stalls; each result is checked against a built-in predictor.
// Depends only on pidj_pkg and the pid_controller_jerk_limited RTL.
module pid_controller_jerk_limited_test;
  import pidj_pkg::*;

  typedef logic signed [95:0] wide_t;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  localparam int   PHASES       = 8;
  localparam int   PHASE_WORDS  = 160;
  localparam int   DRAIN_CYCLES = 16;
  localparam wide_t Q16_HALF    = 96'sd32768;
  localparam wide_t WORD_MAX    = 96'sd2147483647;
  localparam wide_t WORD_MIN    = -96'sd2147483648;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pidj_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pidj_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  pidj_in_t  pending_q[$];
  pidj_out_t expected_q[$];

  int in_sent_cnt = 0, in_taken_cnt = 0;
  int errors = 0, checked = 0, held_seen = 0, n_ticks = 0, n_clears = 0;

  // Predictor copy of the registers and the controller state.
  wide_t kp_gain = 0, ki_gain = 0, kd_gain = 0, int_limit = 0;
  wide_t jerk_step = 96'sd2147483647, band = 0, smooth_k = 0;
  logic  clr_on = 1'b0;
  wide_t integ = 0, last_err = 0, last_deriv = 0, last_pi = 0;
  logic  seen_prev = 1'b0;
  int    settle_cnt = 0;

  pid_controller_jerk_limited u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic wide_t sat32(input wide_t x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic wide_t q16_round(input wide_t x);
    return (x + Q16_HALF) >>> 16;
  endfunction

  function automatic void pid_tick_predict(input pidj_in_t w);
    logic signed [31:0] e32;
    wide_t err, mag_e, raw, deriv, p, ih, il, iterm, pi, lo, hi, corr;
    logic in_band;
    pidj_out_t res;
    if (w.action == ACT_CLEAR) begin
      integ = 0; last_err = 0; last_deriv = 0; last_pi = 0;
      seen_prev = 1'b0; settle_cnt = 0;
      n_clears++;
      return;
    end
    e32 = w.error_in;
    err = wide_t'(e32);
    mag_e = (err < 0) ? -err : err;
    in_band = (mag_e <= band);
    if (!in_band) integ = integ + err;

    raw = err - last_err;
    deriv = sat32(q16_round(raw * (96'sd65536 - smooth_k) + last_deriv * smooth_k));
    last_deriv = deriv;
    last_err = err;

    if (clr_on && in_band && raw == 0) begin
      if (settle_cnt < SETTLE_TICKS) settle_cnt++;
      integ = 0;
    end else begin
      settle_cnt = 0;
    end

    if (integ > int_limit) integ = int_limit;
    if (integ < -int_limit) integ = -int_limit;

    p = q16_round(kp_gain * err);
    ih = integ >>> 16;
    il = integ - ih * 96'sd65536;
    iterm = ki_gain * ih + q16_round(ki_gain * il);
    pi = p + iterm;

    lo = last_pi - jerk_step;
    if (lo > 0) lo = 0;
    hi = last_pi + jerk_step;
    if (hi < 0) hi = 0;
    if (pi < lo) pi = lo;
    if (pi > hi) pi = hi;
    pi = sat32(pi);

    if (seen_prev) begin
      corr = pi + q16_round(kd_gain * deriv);
    end else begin
      corr = pi;
      last_deriv = 0;
    end
    corr = sat32(corr);
    last_pi = pi;
    seen_prev = 1'b1;

    res.correction = corr[31:0];
    res.integral_held = (settle_cnt >= SETTLE_TICKS);
    expected_q.push_back(res);
    n_ticks++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic signed [31:0] s32;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    s32 = val[31:0];
    case (idx)
      REG_KP:     kp_gain = wide_t'(s32);
      REG_KI:     ki_gain = wide_t'(s32);
      REG_KD:     kd_gain = wide_t'(s32);
      REG_ILIMIT: int_limit = wide_t'(val[46:0]);
      REG_JERK:   jerk_step = wide_t'(val[30:0]);
      REG_DBAND:  band = wide_t'(val[30:0]);
      REG_SMOOTH: smooth_k = wide_t'((val[16:0] > Q16_ONE) ? Q16_ONE : val[16:0]);
      REG_CLR_EN: clr_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_taken_cnt != in_sent_cnt || expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_tick(input logic [31:0] v);
    pending_q.push_back('{action: ACT_TICK, error_in: v});
  endfunction

  function automatic void queue_clear();
    pending_q.push_back('{action: ACT_CLEAR, error_in: $urandom});
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return $urandom_range(0, 1 << 18) - (1 << 17);
      2: return $urandom;
      3: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_error(input logic [30:0] dband);
    logic [31:0] mag_v;
    mag_v = (dband == 0) ? 32'h0 : $urandom_range(0, dband);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 21) - (1 << 20);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return $urandom_range(0, 1) ? -mag_v : mag_v;
      4: begin
        mag_v = dband + $urandom_range(0, 1);
        return $urandom_range(0, 1) ? -mag_v : mag_v;
      end
      default: return $urandom_range(0, 1 << 26) - (1 << 25);
    endcase
  endfunction

  // Sender: bursts of words separated by random gaps.
  int gap_left = 0, burst_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken_cnt == in_sent_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
        in_sent_cnt++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that switches between modes.
  rx_mode_t rx_mode = RX_FREE;
  int mode_left = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= rx_tick[2];
      endcase
    end
  end

  always @(posedge clk) begin
    pidj_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no tick pending: correction %0d", out_data.correction);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.correction !== want.correction) begin
            $error("correction: expected %0d, got %0d", want.correction, out_data.correction);
            errors++;
          end
          if (out_data.integral_held !== want.integral_held) begin
            $error("integral_held: expected %0b, got %0b", want.integral_held,
                   out_data.integral_held);
            errors++;
          end
          if (want.integral_held) held_seen++;
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        in_taken_cnt++;
        pid_tick_predict(in_data);
      end
    end
  end

  initial begin
    logic [31:0] kp, ki, kd, v;
    logic [46:0] lim;
    logic [30:0] jerk, dband;
    logic [16:0] sm;
    logic ce;
    int n, r, len;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = -1; ph < PHASES; ph++) begin
      if (ph < 0) begin
        kp = 32'h0001_0000; ki = 32'h0000_8000; kd = 32'h0000_4000;
        lim = 47'h50_0000; jerk = 31'h0010_0000; dband = 31'h0001_0000;
        sm = 17'h0_8000; ce = 1'b1;
      end else if (ph == 0) begin
        kp = 32'h7FFF_FFFF; ki = 32'h8000_0000; kd = 32'h7FFF_FFFF;
        lim = 47'h7FFF_FFFF_FFFF; jerk = 31'h0; dband = 31'h7FFF_FFFF;
        sm = Q16_ONE; ce = 1'b1;
      end else if (ph == 1) begin
        kp = 32'h8000_0000; ki = 32'h7FFF_FFFF; kd = 32'h8000_0000;
        lim = 47'h0; jerk = 31'h7FFF_FFFF; dband = 31'h0;
        sm = 17'h1_FFFF; ce = 1'b0;
      end else begin
        kp = pick_gain(); ki = pick_gain(); kd = pick_gain();
        case ($urandom_range(0, 2))
          0: lim = 47'($urandom_range(0, 1 << 24));
          1: lim = 47'({$urandom_range(0, 15), $urandom});
          default: lim = 47'({$urandom, $urandom} >> 17);
        endcase
        case ($urandom_range(0, 3))
          0: jerk = 31'h0;
          1: jerk = 31'($urandom_range(0, 1 << 20));
          2: jerk = 31'($urandom >> 1);
          default: jerk = 31'h7FFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
          0: dband = 31'h0;
          1: dband = 31'($urandom_range(0, 1 << 18));
          default: dband = 31'($urandom >> 1);
        endcase
        case ($urandom_range(0, 3))
          0: sm = 17'h0;
          1: sm = Q16_ONE;
          2: sm = 17'($urandom_range(0, 65536));
          default: sm = 17'($urandom_range(65537, 131071));
        endcase
        ce = ($urandom_range(0, 3) != 0);
      end

      write_reg(REG_KP, CFG_DATA_W'(kp));
      write_reg(REG_KI, CFG_DATA_W'(ki));
      write_reg(REG_KD, CFG_DATA_W'(kd));
      write_reg(REG_ILIMIT, lim);
      write_reg(REG_JERK, CFG_DATA_W'(jerk));
      write_reg(REG_DBAND, CFG_DATA_W'(dband));
      write_reg(REG_SMOOTH, CFG_DATA_W'(sm));
      write_reg(REG_CLR_EN, CFG_DATA_W'(ce));

      if (ph < 0) begin
        queue_clear();
        queue_tick(32'h7FFF_FFFF);
        queue_tick(32'h8000_0000);
        queue_tick(32'h0);
        queue_tick(32'h1);
        queue_tick(32'hFFFF_FFFF);
        queue_tick(32'h0001_0000);
        queue_tick(32'h0001_0001);
        queue_tick(32'hFFFF_0000);
        queue_tick(32'hFFFE_FFFF);
        repeat (12) queue_tick(32'h0000_8000);
        queue_tick(32'h0002_0000);
        queue_clear();
        queue_tick(32'h1234_5678);
      end else begin
        n = 0;
        while (n < PHASE_WORDS) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            queue_clear();
            n++;
          end else if (r < 30) begin
            v = (dband == 0) ? 32'h0 : $urandom_range(0, dband);
            if ($urandom_range(0, 1)) v = -v;
            len = $urandom_range(1, 14);
            repeat (len) queue_tick(v);
            n += len;
          end else begin
            queue_tick(pick_error(dband));
            n++;
          end
        end
      end
      drain();
    end

    $display("Checked %0d results from %0d tick words and %0d clear words over %0d settings.",
             checked, n_ticks, n_clears, PHASES + 1);
    $display("The settled flag was expected high on %0d of those results.", held_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/pidj_pkg.sv
rtl/pidj_mul.sv
rtl/pidj_datapath.sv
rtl/pidj_ctrl.sv
rtl/pid_controller_jerk_limited.sv
tb/pid_controller_jerk_limited_test.sv
